FILE: hw/rtl/tpiq_pkg.sv
// Shared types, constants and codes for the touch pad integrating qualifier.
`default_nettype none
package tpiq_pkg;

    localparam int CHANNELS = 10;
    localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int INTEG_W  = 9;
    localparam int LEVEL_W  = 7;
    localparam int CFG_W    = 16;
    localparam int CFG_IX_W = 2;
    localparam int CODE_W   = 2;

    localparam logic [CODE_W-1:0] EV_NONE    = 2'd0;
    localparam logic [CODE_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [CODE_W-1:0] EV_RELEASE = 2'd2;

    localparam logic [CFG_IX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IX_W-1:0] REG_DEBOUNCE  = 2'd1;
    localparam logic [CFG_IX_W-1:0] REG_LEVEL     = 2'd2;
    localparam logic [CFG_IX_W-1:0] REG_ATTACK    = 2'd3;

    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 16'd57;
    localparam logic [CFG_W-1:0]    DEBOUNCE_RST  = 16'd400;
    localparam logic [LEVEL_W-1:0]  LEVEL_RST     = 7'd10;
    localparam logic [LEVEL_W-1:0]  ATTACK_RST    = 7'd5;

    typedef struct packed {
        logic [SAMPLE_W-1:0] touch_threshold;
        logic [CFG_W-1:0]    debounce_ms;
        logic [LEVEL_W-1:0]  check_level;
        logic [LEVEL_W-1:0]  attack_step;
    } cfg_t;

    typedef struct packed {
        logic signed [INTEG_W-1:0] integ;
        logic                      flag;
        logic [TIME_W-1:0]         last_ms;
    } chan_state_t;

    localparam int STATE_W = $bits(chan_state_t);

endpackage
`default_nettype wire

FILE: hw/rtl/tpiq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module tpiq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/tpiq_cfg_regs.sv
// Configuration registers of the touch qualifier.
`default_nettype none
module tpiq_cfg_regs
    import tpiq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire logic [CFG_IX_W-1:0] index,
    input  wire logic [CFG_W-1:0]    data,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.touch_threshold <= THRESHOLD_RST;
            cfg_reg.debounce_ms     <= DEBOUNCE_RST;
            cfg_reg.check_level     <= LEVEL_RST;
            cfg_reg.attack_step     <= ATTACK_RST;
        end
        else if (wr_en)
        begin
            unique case (index)
                REG_THRESHOLD: cfg_reg.touch_threshold <= data;
                REG_DEBOUNCE:  cfg_reg.debounce_ms     <= data;
                REG_LEVEL:     cfg_reg.check_level     <= data[LEVEL_W-1:0];
                REG_ATTACK:    cfg_reg.attack_step     <= data[LEVEL_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/tpiq_update.sv
// Per-channel integrator step with hold-off, press and release detection.
`default_nettype none
module tpiq_update
    import tpiq_pkg::*;
(
    input  wire cfg_t                cfg,
    input  wire chan_state_t         cur,
    input  wire logic [SAMPLE_W-1:0] sample,
    input  wire logic [TIME_W-1:0]   now_ms,
    output chan_state_t              nxt,
    output logic      [CODE_W-1:0]   code
);

    localparam int VW = INTEG_W + 1;

    logic [TIME_W-1:0]   elapsed;
    logic                open;
    logic signed [VW-1:0] lvl;
    logic signed [VW-1:0] v0;
    logic signed [VW-1:0] v1;
    logic signed [VW-1:0] v2;
    logic signed [VW-1:0] v3;
    logic signed [VW-1:0] rise;
    logic                flag1;
    logic                flag2;
    logic                press;
    logic                release_hit;

    always_comb
    begin
        elapsed = now_ms - cur.last_ms;
        open    = elapsed > TIME_W'(cfg.debounce_ms);
        lvl     = signed'(VW'(cfg.check_level));
        v0      = VW'(cur.integ);
        rise    = v0 + signed'(VW'(cfg.attack_step));

        priority if (open && (v0 < lvl) && (sample < cfg.touch_threshold))
        begin
            v1 = (rise > lvl) ? lvl : rise;
        end
        else if (open && (v0 > -lvl))
        begin
            v1 = v0 - VW'(1);
        end
        else
        begin
            v1 = v0;
        end

        press = (v1 == lvl) && !cur.flag;
        v2    = press ? v1 + VW'(1) : v1;
        flag1 = press ? 1'b1 : cur.flag;

        release_hit = (v2 == -lvl) && flag1;
        v3    = release_hit ? v2 - VW'(1) : v2;
        flag2 = release_hit ? 1'b0 : flag1;

        nxt.integ   = v3[INTEG_W-1:0];
        nxt.flag    = flag2;
        nxt.last_ms = (press || release_hit) ? now_ms : cur.last_ms;

        priority if (release_hit)
        begin
            code = EV_RELEASE;
        end
        else if (press)
        begin
            code = EV_PRESS;
        end
        else
        begin
            code = EV_NONE;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/touch_pad_integrating_qualifier_unit.sv
// Top level of the touch pad integrating qualifier.
// The block takes one request per clock cycle while the output side does not stall
// and returns exactly one result for each, in order; a request is held in the s1
// stage register, then its result in the output register. The
// per-channel state (integrator, touched flag, last event time) lives in a small RAM
// with a registered read: the read is issued when a request is accepted, and the
// update is written back when the request leaves the s1 stage. A write-back register
// forwards the latest update to a request for the same channel that follows directly.
// Per-entry valid bits make never-written channels read as zero, so no clearing pass
// follows reset. A channel index at or beyond the channel count changes no state and
// reports no event and an untouched pad.
`default_nettype none
module touch_pad_integrating_qualifier_unit
    import tpiq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                cfg_wr_en,
    input  wire logic [CFG_IX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_data,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CH_W-1:0]     channel,
    input  wire logic [SAMPLE_W-1:0] touch_sample,
    input  wire logic [TIME_W-1:0]   now_ms,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [CH_W-1:0]     event_channel,
    output logic      [CODE_W-1:0]   event_code,
    output logic                     touched
);

    cfg_t cfg;

    logic                accept;
    logic                s1_fire;
    logic                wr_en;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_range;

    logic                s1_valid_reg;
    logic [CH_W-1:0]     s1_channel_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_in_range_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [TIME_W-1:0]   s1_now_reg;

    logic [CHANNELS-1:0] ent_valid_reg;
    logic [CHANNELS-1:0] ent_valid_next;

    logic                fwd_valid_reg;
    logic [ADDR_W-1:0]   fwd_addr_reg;
    chan_state_t         fwd_data_reg;

    logic [STATE_W-1:0]  ram_rdata;
    chan_state_t         cur_state;
    chan_state_t         new_state;
    logic [CODE_W-1:0]   new_code;

    logic                out_valid_reg;
    logic [CH_W-1:0]     out_channel_reg;
    logic [CODE_W-1:0]   out_code_reg;
    logic                out_touched_reg;

    tpiq_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    assign s1_fire  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;
    assign accept   = in_valid && in_ready;
    assign in_addr  = ADDR_W'(channel);
    assign in_range = 32'(channel) < CHANNELS;
    assign wr_en    = s1_fire && s1_in_range_reg;

    tpiq_ram #(
        .WIDTH (STATE_W),
        .DEPTH (CHANNELS),
        .AW    (ADDR_W)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_state),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        priority if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            cur_state = fwd_data_reg;
        end
        else if (s1_in_range_reg && ent_valid_reg[s1_addr_reg])
        begin
            cur_state = chan_state_t'(ram_rdata);
        end
        else
        begin
            cur_state = '0;
        end
    end

    tpiq_update u_update (
        .cfg    (cfg),
        .cur    (cur_state),
        .sample (s1_sample_reg),
        .now_ms (s1_now_reg),
        .nxt    (new_state),
        .code   (new_code)
    );

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (wr_en)
        begin
            ent_valid_next[s1_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ent_valid_reg <= '0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_channel_reg  <= channel;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= in_range;
            s1_sample_reg   <= touch_sample;
            s1_now_reg      <= now_ms;
        end
        if (wr_en)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= new_state;
        end
        if (s1_fire)
        begin
            out_channel_reg <= s1_channel_reg;
            out_code_reg    <= s1_in_range_reg ? new_code : EV_NONE;
            out_touched_reg <= s1_in_range_reg && new_state.flag;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_channel = out_channel_reg;
    assign event_code    = out_code_reg;
    assign touched       = out_touched_reg;

endmodule
`default_nettype wire
